FILE: design/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
`default_nettype none

package stbs_pkg;

  // Field widths
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CAP_W    = 11;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned STATUS_W = 2;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic                load;    // capture the input beat, open the search range
    logic                rd_en;   // issue a table read at the midpoint
    logic                step;    // narrow the search range after a miss
    logic                write;   // store the key at the fill slot
    logic                emit;    // load the output register
    logic [STATUS_W-1:0] status;  // status of the emitted result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic can_append;   // fill count below capacity and depth
    logic range_empty;  // low bound has met the high bound
    logic probe_eq;     // probed word equals the key
    logic out_free;     // output register can take a result this cycle
  } stat_t;

endpackage

`default_nettype wire

FILE: design/stbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/stbs_ctrl.sv
// Controller state machine for the sorted table binary search block.
`default_nettype none

module stbs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_op,
  output logic                in_ready,
  input  wire stbs_pkg::stat_t sts,
  output stbs_pkg::cmd_t      cmd
);

  import stbs_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_APPEND = 2'd1;
  localparam logic [1:0] S_PROBE  = 2'd2;
  localparam logic [1:0] S_CMP    = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == OP_SEARCH) ? S_PROBE : S_APPEND;
        end
      end
      S_APPEND: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.can_append) begin
            cmd.write  = 1'b1;
            cmd.status = ST_APPENDED;
          end else begin
            cmd.status = ST_DROPPED;
          end
          state_nxt = S_IDLE;
        end
      end
      S_PROBE: begin
        if (sts.range_empty) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_NOTFOUND;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.probe_eq) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_FOUND;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // A result is emitted only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result emitted into a busy output register");

  // An accepted beat always moves the controller out of idle
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r != S_IDLE))
    else $error("controller stayed idle after accepting a beat");

  // Every table read is followed by a compare cycle
  a_read_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> (state_r == S_CMP))
    else $error("table read not followed by a compare");

  // A write happens only when the table has room
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (sts.can_append && cmd.emit))
    else $error("table write without room or result");
`endif

endmodule

`default_nettype wire

FILE: design/stbs_dp.sv
// Datapath for the sorted table binary search block: table, bounds, result register.
`default_nettype none

module stbs_dp #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [stbs_pkg::CAP_W-1:0]     cfg_wr_data,
  input  wire logic [stbs_pkg::VAL_W-1:0]     in_value,
  input  wire stbs_pkg::cmd_t                 cmd,
  output stbs_pkg::stat_t                     sts,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [stbs_pkg::STATUS_W-1:0]  out_status,
  output logic      [stbs_pkg::IDX_W-1:0]     out_index
);

  import stbs_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned XW   = (CW > IDX_W) ? CW : IDX_W;

  logic [CAP_W-1:0]    capacity_r;
  logic [CW-1:0]       fill_r;
  logic [CW-1:0]       lo_r;
  logic [CW-1:0]       lo_nxt;
  logic [CW-1:0]       hi_r;
  logic [CW-1:0]       hi_nxt;
  logic [AW-1:0]       mid_r;
  logic [VAL_W-1:0]    key_r;
  logic [VAL_W-1:0]    rd_data;
  logic [CW:0]         sum_w;
  logic [CW-1:0]       half_w;
  logic [AW-1:0]       mid_w;
  logic                probe_lt;
  logic [XW-1:0]       fill_ext;
  logic [XW-1:0]       mid_ext;
  logic [IDX_W-1:0]    index_w;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]    out_index_r;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  // Table storage
  stbs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.write),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (key_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (mid_w),
    .rd_data (rd_data)
  );

  // Midpoint of the open range [lo, hi), only used while lo < hi
  assign sum_w  = {1'b0, lo_r} + {1'b0, hi_r} - {{CW{1'b0}}, 1'b1};
  assign half_w = sum_w[CW:1];
  assign mid_w  = half_w[AW-1:0];

  // Signed compare of probe against key
  assign probe_lt = $signed(rd_data) < $signed(key_r);

  // Status to controller
  always_comb begin
    sts.can_append  = (fill_r < CW'(DEPTH)) &&
                      (CMPW'(fill_r) < CMPW'(capacity_r));
    sts.range_empty = !(lo_r < hi_r);
    sts.probe_eq    = (rd_data == key_r);
    sts.out_free    = !out_valid_r || out_ready;
  end

  // Range bounds: open on load, narrow on a miss
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.load) begin
      lo_nxt = '0;
      hi_nxt = fill_r;
    end else if (cmd.step) begin
      if (probe_lt) begin
        lo_nxt = CW'(mid_r) + {{(CW-1){1'b0}}, 1'b1};
      end else begin
        hi_nxt = CW'(mid_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r   <= '0;
      hi_r   <= '0;
      fill_r <= '0;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      if (cmd.write) begin
        fill_r <= fill_r + {{(CW-1){1'b0}}, 1'b1};
      end
    end
  end

  // Hold key and probe address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_value;
    end
    if (cmd.rd_en) begin
      mid_r <= mid_w;
    end
  end

  // Result index in the low bits
  assign fill_ext = XW'(fill_r);
  assign mid_ext  = XW'(mid_r);

  always_comb begin
    case (cmd.status)
      ST_APPENDED: index_w = fill_ext[IDX_W-1:0];
      ST_FOUND:    index_w = mid_ext[IDX_W-1:0];
      default:     index_w = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_index_r  <= index_w;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_index  = out_index_r;

`ifndef SYNTHESIS
  // Fill count never passes the table depth
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count beyond table depth");

  // Search range stays well formed
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (lo_r <= hi_r) && (hi_r <= fill_r))
    else $error("search range out of order");

  // Each write advances the fill count by one
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> (fill_r == $past(fill_r) + {{(CW-1){1'b0}}, 1'b1}))
    else $error("fill count did not advance on write");
`endif

endmodule

`default_nettype wire

FILE: design/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
//
//   channel  dir  handshake              payload
//   in       in   in_tvalid/in_tready    in_tuser[0] opcode, in_tdata[31:0] value
//   out      out  out_tvalid/out_tready  out_tuser[1:0] status, out_tdata[9:0] index
//   cfg      in   cfg_wr_en              cfg_wr_data[10:0] capacity
//
// One item at a time. An append is accepted, then written, or dropped when there is no
// room, as its result is emitted. A search is accepted, then each probe issues a read
// at the midpoint and compares against the table's registered read data; a miss ends
// with one more probe step that finds the range empty.
// Reset clears the fill count and loads capacity 1024; table contents are unknown.
// A result waiting in the output register stalls completion, not acceptance.
`default_nettype none

module sorted_table_binary_search #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input beats
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [0:0]  in_tuser,   // [0] opcode
  // Result beats
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [9:0] index, [15:10] zero
  output logic      [1:0]  out_tuser,  // [1:0] status
  // Capacity register
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data
);

  import stbs_pkg::*;

  cmd_t             cmd;
  stat_t            sts;
  logic [IDX_W-1:0] index_w;

  // Controller
  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser[0]),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  stbs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_value    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_index   (index_w)
  );

  // Pad index to whole bytes
  assign out_tdata = {6'b0, index_w};

endmodule

`default_nettype wire
